>>> rtl/dosp_pkg.sv
// shared constants, codes and types of the dual-order sorted peak table
package dosp_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int MZ_W     = 32;
    localparam int INT_W    = 32;
    localparam int SUM_W    = 40;
    localparam int ENTRY_W  = MZ_W + INT_W;

    // request codes
    localparam logic [3:0] REQ_ADD      = 4'd0;
    localparam logic [3:0] REQ_REMOVE   = 4'd1;
    localparam logic [3:0] REQ_CONTAINS = 4'd2;
    localparam logic [3:0] REQ_INDEX_OF = 4'd3;
    localparam logic [3:0] REQ_RANK     = 4'd4;
    localparam logic [3:0] REQ_LEFT     = 4'd5;
    localparam logic [3:0] REQ_RIGHT    = 4'd6;
    localparam logic [3:0] REQ_LARGER   = 4'd7;
    localparam logic [3:0] REQ_SMALLER  = 4'd8;
    localparam logic [3:0] REQ_NEAREST  = 4'd9;
    localparam logic [3:0] REQ_MAX_RNG  = 4'd10;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [MZ_W-1:0]  mz;
        logic [INT_W-1:0] inten;
    } entry_t;

endpackage

>>> rtl/dosp_req_if.sv
// request channel: valid, ready and the request payload
interface dosp_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  req_type;
    logic [31:0] mz_key;
    logic [31:0] mz_upper;
    logic [31:0] intensity_value;
    logic [7:0]  rank;
    logic        order_select;

    modport source (output valid, req_type, mz_key, mz_upper, intensity_value, rank,
                    order_select, input ready);
    modport sink (input valid, req_type, mz_key, mz_upper, intensity_value, rank,
                  order_select, output ready);
endinterface

>>> rtl/dosp_rsp_if.sv
// response channel: valid, ready and the result payload
interface dosp_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  index;
    logic [31:0] peak_mz;
    logic [31:0] peak_intensity;
    logic [8:0]  entry_count;
    logic [39:0] intensity_total;

    modport source (output valid, status, index, peak_mz, peak_intensity, entry_count,
                    intensity_total, input ready);
    modport sink (input valid, status, index, peak_mz, peak_intensity, entry_count,
                  intensity_total, output ready);
endinterface

>>> rtl/dosp_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
module dosp_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/dual_order_sorted_peak_table_core.sv
// top level: sequencer over the m/z-ordered and intensity-ordered peak memories
//
//  channel | modport | transaction
//  req     | sink    | one request (op code, m/z key, upper bound, intensity, rank, order)
//  rsp     | source  | one result (status, index, peak, count, intensity sum)
//
// every request scans the held entries of both memories through a shared read address,
// one entry a cycle. add and remove then shift the memories one entry at a time, each
// step a read and then a write.
// reset clears the state, count, sum and valid flags; memory contents need no clearing.
// the result sits in an output register, so a new request is taken while it waits;
// a stalled response holds only the final load of the next result.
module dual_order_sorted_peak_table_core (
    input  logic       clk,
    input  logic       rst_n,
    dosp_req_if.sink   req,
    dosp_rsp_if.source rsp
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_RESOLVE = 4'd2;
    localparam logic [3:0] S_INS_RD  = 4'd3;
    localparam logic [3:0] S_INS_WR  = 4'd4;
    localparam logic [3:0] S_DEL_RD  = 4'd5;
    localparam logic [3:0] S_DEL_WR  = 4'd6;
    localparam logic [3:0] S_RESP    = 4'd7;

    localparam logic [dosp_pkg::CNT_W-1:0] CNT_ONE = dosp_pkg::CNT_W'(1);
    localparam logic [dosp_pkg::CNT_W-1:0] CNT_CAP = dosp_pkg::CNT_W'(dosp_pkg::CAPACITY);

    logic [3:0]                   state_reg, state_next;
    logic [dosp_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [dosp_pkg::SUM_W-1:0]   sum_reg, sum_next;

    // captured request
    logic [3:0]                   op_reg;
    logic [dosp_pkg::MZ_W-1:0]    key_reg, upper_reg;
    logic [dosp_pkg::INT_W-1:0]   thr_reg;
    logic [7:0]                   rank_reg;
    logic                         sel_reg;

    // scan pipeline
    logic [dosp_pkg::CNT_W-1:0]   scan_i_reg, scan_i_next;
    logic                         pv_reg, pv_next;
    logic [dosp_pkg::CNT_W-1:0]   pidx_reg, pidx_next;

    // scan accumulators
    logic [dosp_pkg::CNT_W-1:0]   cb_reg, cab_reg, ia_reg, iae_reg, ip_pos_reg, best_pos_reg;
    logic                         re_f_reg, hit_f_reg, sm_f_reg, ip_f_reg, best_f_reg;
    dosp_pkg::entry_t             left_reg, le_reg, re_reg, hit_reg, lg_reg, sm_reg;
    dosp_pkg::entry_t             rk_mz_reg, rk_int_reg, best_reg;

    // shift loop
    logic [dosp_pkg::CNT_W-1:0]   j_reg, j_next;
    logic [dosp_pkg::CNT_W-1:0]   p_reg, q_reg;
    dosp_pkg::entry_t             new_reg;

    // held result
    logic [1:0]                   hst_reg;
    logic [dosp_pkg::CNT_W-1:0]   hidx_reg;
    dosp_pkg::entry_t             hans_reg;

    // output register
    logic                         ov_reg;

    // memory ports
    logic                         mz_we, in_we;
    logic [dosp_pkg::ADDR_W-1:0]  raddr, waddr;
    dosp_pkg::entry_t             mz_wd, in_wd, mz_rd, in_rd;
    logic [dosp_pkg::ENTRY_W-1:0] mz_rd_raw, in_rd_raw;

    logic                         accept;
    logic                         resp_load;

    // resolve-stage decisions
    logic [1:0]                   r_st;
    logic [dosp_pkg::CNT_W-1:0]   r_idx;
    dosp_pkg::entry_t             r_ans;
    logic                         r_add, r_del;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign resp_load = (state_reg == S_RESP) && (!ov_reg || rsp.ready);
    assign mz_rd     = mz_rd_raw;
    assign in_rd     = in_rd_raw;

    dosp_ram #(.DEPTH(dosp_pkg::CAPACITY), .WIDTH(dosp_pkg::ENTRY_W)) u_mz_ram (
        .clk   (clk),
        .we    (mz_we),
        .waddr (waddr),
        .wdata (mz_wd),
        .raddr (raddr),
        .rdata (mz_rd_raw)
    );

    dosp_ram #(.DEPTH(dosp_pkg::CAPACITY), .WIDTH(dosp_pkg::ENTRY_W)) u_int_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (waddr),
        .wdata (in_wd),
        .raddr (raddr),
        .rdata (in_rd_raw)
    );

    // pick the answer from the scan results
    always_comb
    begin
        r_st  = dosp_pkg::ST_ABSENT;
        r_idx = '0;
        r_ans = '0;
        r_add = 1'b0;
        r_del = 1'b0;
        case (op_reg)
            dosp_pkg::REQ_ADD:
            begin
                if (hit_f_reg)
                begin
                    r_st = dosp_pkg::ST_ABSENT;
                end
                else if (cnt_reg >= CNT_CAP)
                begin
                    r_st = dosp_pkg::ST_FULL;
                end
                else
                begin
                    r_st  = dosp_pkg::ST_OK;
                    r_idx = cb_reg;
                    r_ans = '{mz: key_reg, inten: thr_reg};
                    r_add = 1'b1;
                end
            end
            dosp_pkg::REQ_REMOVE:
            begin
                if (hit_f_reg && hit_reg.inten == thr_reg && ip_f_reg)
                begin
                    r_st  = dosp_pkg::ST_OK;
                    r_idx = cb_reg;
                    r_ans = hit_reg;
                    r_del = 1'b1;
                end
            end
            dosp_pkg::REQ_CONTAINS:
            begin
                if (hit_f_reg)
                begin
                    r_st  = dosp_pkg::ST_OK;
                    r_idx = cb_reg;
                    r_ans = hit_reg;
                end
            end
            dosp_pkg::REQ_INDEX_OF:
            begin
                if (sel_reg)
                begin
                    if (ip_f_reg)
                    begin
                        r_st  = dosp_pkg::ST_OK;
                        r_idx = ip_pos_reg;
                        r_ans = '{mz: key_reg, inten: thr_reg};
                    end
                end
                else if (hit_f_reg && hit_reg.inten == thr_reg)
                begin
                    r_st  = dosp_pkg::ST_OK;
                    r_idx = cb_reg;
                    r_ans = hit_reg;
                end
            end
            dosp_pkg::REQ_RANK:
            begin
                if (dosp_pkg::CNT_W'(rank_reg) < cnt_reg)
                begin
                    r_st  = dosp_pkg::ST_OK;
                    r_idx = dosp_pkg::CNT_W'(rank_reg);
                    r_ans = sel_reg ? rk_int_reg : rk_mz_reg;
                end
            end
            dosp_pkg::REQ_LEFT:
            begin
                if (cb_reg != '0)
                begin
                    r_st  = dosp_pkg::ST_OK;
                    r_idx = cb_reg - CNT_ONE;
                    r_ans = left_reg;
                end
            end
            dosp_pkg::REQ_RIGHT:
            begin
                if (re_f_reg)
                begin
                    r_st  = dosp_pkg::ST_OK;
                    r_idx = cab_reg;
                    r_ans = re_reg;
                end
            end
            dosp_pkg::REQ_LARGER:
            begin
                if (ia_reg != '0)
                begin
                    r_st  = dosp_pkg::ST_OK;
                    r_idx = ia_reg - CNT_ONE;
                    r_ans = lg_reg;
                end
            end
            dosp_pkg::REQ_SMALLER:
            begin
                if (sm_f_reg)
                begin
                    r_st  = dosp_pkg::ST_OK;
                    r_idx = iae_reg;
                    r_ans = sm_reg;
                end
            end
            dosp_pkg::REQ_NEAREST:
            begin
                if (cnt_reg != '0)
                begin
                    r_st = dosp_pkg::ST_OK;
                    if (cab_reg == '0)
                    begin
                        r_idx = '0;
                        r_ans = re_reg;
                    end
                    else if (!re_f_reg ||
                             !((re_reg.mz - key_reg) < (key_reg - le_reg.mz)))
                    begin
                        r_idx = cab_reg - CNT_ONE;
                        r_ans = le_reg;
                    end
                    else
                    begin
                        r_idx = cab_reg;
                        r_ans = re_reg;
                    end
                end
            end
            dosp_pkg::REQ_MAX_RNG:
            begin
                if (best_f_reg)
                begin
                    r_st  = dosp_pkg::ST_OK;
                    r_idx = best_pos_reg;
                    r_ans = best_reg;
                end
            end
            default:
            begin
                r_st = dosp_pkg::ST_ABSENT;
            end
        endcase
    end

    // sequencer and memory port control
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        scan_i_next = scan_i_reg;
        pv_next     = 1'b0;
        pidx_next   = pidx_reg;
        j_next      = j_reg;
        raddr       = '0;
        waddr       = j_reg[dosp_pkg::ADDR_W-1:0];
        mz_we       = 1'b0;
        in_we       = 1'b0;
        mz_wd       = mz_rd;
        in_wd       = in_rd;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = S_SCAN;
                    scan_i_next = '0;
                end
            end
            S_SCAN:
            begin
                if (scan_i_reg < cnt_reg)
                begin
                    raddr       = scan_i_reg[dosp_pkg::ADDR_W-1:0];
                    pv_next     = 1'b1;
                    pidx_next   = scan_i_reg;
                    scan_i_next = scan_i_reg + CNT_ONE;
                end
                else if (!pv_reg)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (r_add)
                begin
                    cnt_next   = cnt_reg + CNT_ONE;
                    sum_next   = sum_reg + dosp_pkg::SUM_W'(thr_reg);
                    j_next     = cnt_reg;
                    state_next = S_INS_RD;
                end
                else if (r_del)
                begin
                    cnt_next   = cnt_reg - CNT_ONE;
                    sum_next   = sum_reg - dosp_pkg::SUM_W'(thr_reg);
                    j_next     = '0;
                    state_next = (cnt_reg > CNT_ONE) ? S_DEL_RD : S_RESP;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_INS_RD:
            begin
                raddr      = dosp_pkg::ADDR_W'(j_reg - CNT_ONE);
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                // move up above the insertion point, drop the new peak at it
                if (j_reg > p_reg)
                begin
                    mz_we = 1'b1;
                end
                else if (j_reg == p_reg)
                begin
                    mz_we = 1'b1;
                    mz_wd = new_reg;
                end
                if (j_reg > q_reg)
                begin
                    in_we = 1'b1;
                end
                else if (j_reg == q_reg)
                begin
                    in_we = 1'b1;
                    in_wd = new_reg;
                end
                if (j_reg == '0)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    j_next     = j_reg - CNT_ONE;
                    state_next = S_INS_RD;
                end
            end
            S_DEL_RD:
            begin
                raddr      = dosp_pkg::ADDR_W'(j_reg + CNT_ONE);
                state_next = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                // close the gap left by the removed peak
                mz_we  = (j_reg >= p_reg);
                in_we  = (j_reg >= q_reg);
                j_next = j_reg + CNT_ONE;
                state_next = ((j_reg + CNT_ONE) < cnt_reg) ? S_DEL_RD : S_RESP;
            end
            S_RESP:
            begin
                if (resp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            pv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            pv_reg    <= pv_next;
            if (resp_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // request capture, scan accumulation and result registers
    always_ff @(posedge clk)
    begin
        scan_i_reg <= scan_i_next;
        pidx_reg   <= pidx_next;
        j_reg      <= j_next;
        if (accept)
        begin
            op_reg     <= req.req_type;
            key_reg    <= req.mz_key;
            upper_reg  <= req.mz_upper;
            thr_reg    <= req.intensity_value;
            rank_reg   <= req.rank;
            sel_reg    <= req.order_select;
            cb_reg     <= '0;
            cab_reg    <= '0;
            ia_reg     <= '0;
            iae_reg    <= '0;
            re_f_reg   <= 1'b0;
            hit_f_reg  <= 1'b0;
            sm_f_reg   <= 1'b0;
            ip_f_reg   <= 1'b0;
            best_f_reg <= 1'b0;
        end
        if (state_reg == S_SCAN && pv_reg)
        begin
            // m/z order
            if (mz_rd.mz < key_reg)
            begin
                cb_reg   <= cb_reg + CNT_ONE;
                left_reg <= mz_rd;
            end
            if (mz_rd.mz <= key_reg)
            begin
                cab_reg <= cab_reg + CNT_ONE;
                le_reg  <= mz_rd;
            end
            else if (!re_f_reg)
            begin
                re_f_reg <= 1'b1;
                re_reg   <= mz_rd;
            end
            if (mz_rd.mz == key_reg)
            begin
                hit_f_reg <= 1'b1;
                hit_reg   <= mz_rd;
            end
            if (mz_rd.mz > key_reg && mz_rd.mz < upper_reg &&
                (!best_f_reg || mz_rd.inten > best_reg.inten))
            begin
                best_f_reg   <= 1'b1;
                best_reg     <= mz_rd;
                best_pos_reg <= pidx_reg;
            end
            // intensity order
            if (in_rd.inten > thr_reg)
            begin
                ia_reg <= ia_reg + CNT_ONE;
                lg_reg <= in_rd;
            end
            if (in_rd.inten >= thr_reg)
            begin
                iae_reg <= iae_reg + CNT_ONE;
            end
            else if (!sm_f_reg)
            begin
                sm_f_reg <= 1'b1;
                sm_reg   <= in_rd;
            end
            if (!ip_f_reg && in_rd.mz == key_reg && in_rd.inten == thr_reg)
            begin
                ip_f_reg   <= 1'b1;
                ip_pos_reg <= pidx_reg;
            end
            // rank read
            if (pidx_reg == dosp_pkg::CNT_W'(rank_reg))
            begin
                rk_mz_reg  <= mz_rd;
                rk_int_reg <= in_rd;
            end
        end
        if (state_reg == S_RESOLVE)
        begin
            hst_reg  <= r_st;
            hidx_reg <= r_idx;
            hans_reg <= r_ans;
            p_reg    <= cb_reg;
            q_reg    <= r_add ? ia_reg : ip_pos_reg;
            new_reg  <= '{mz: key_reg, inten: thr_reg};
        end
        if (resp_load)
        begin
            rsp.status          <= hst_reg;
            rsp.index           <= hidx_reg[7:0];
            rsp.peak_mz         <= hans_reg.mz;
            rsp.peak_intensity  <= hans_reg.inten;
            rsp.entry_count     <= cnt_reg;
            rsp.intensity_total <= sum_reg;
        end
    end

    assign rsp.valid = ov_reg;

    // the held count never passes the capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_CAP)
        else $error("held count above capacity");

    // the count moves by at most one, and only when resolving
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_RESOLVE) |=> $stable(cnt_reg))
        else $error("held count changed outside resolve");

    // a result load returns the sequencer to idle with the result held valid
    a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
        resp_load |=> (state_reg == S_IDLE) && ov_reg)
        else $error("response load did not finish the request");

endmodule
